@@ rtl/core/lru_k_frame_replacer_top_assert.svh @@
// assertion macros for the lru-k frame replacer
`ifndef LRU_K_FRAME_REPLACER_TOP_ASSERT_SVH
`define LRU_K_FRAME_REPLACER_TOP_ASSERT_SVH

// expression holds at every clock edge out of reset
`define LKFR_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define LKFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/lkfr_pkg.sv @@
package lkfr_pkg;

   localparam int FRAME_W     = 6;
   localparam int FRAME_LIMIT = 64;
   localparam int COUNT_W     = 7;
   localparam int DEPTH_W     = 3;
   localparam int TOTAL_W     = 7;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_COUNT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HISTORY_DEPTH = 2'd1;

   localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET   = 7'd64;
   localparam logic [DEPTH_W-1:0] HISTORY_DEPTH_RESET = 3'd2;

   typedef enum logic [1:0] {
      OP_ACCESS    = 2'd0,
      OP_SET_EVICT = 2'd1,
      OP_REMOVE    = 2'd2,
      OP_EVICT     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NO_VICTIM = 2'd1,
      ST_BAD_FRAME = 2'd2,
      ST_PINNED    = 2'd3
   } status_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_DECODE = 6'b000010,
      S_META   = 6'b000100,
      S_SHIFT  = 6'b001000,
      S_SCAN   = 6'b010000,
      S_DONE   = 6'b100000
   } fsm_type;

   typedef struct packed {
      opcode_type         opcode;
      logic [FRAME_W-1:0] frame;
      logic               evictable_flag;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic               victim_valid;
      logic [FRAME_W-1:0] victim_id;
      logic [TOTAL_W-1:0] evictable_total;
   } rsp_type;

endpackage

@@ rtl/core/lru_k_frame_replacer_top.sv @@
// LRU-K frame replacer. Tracks up to min(MAX_FRAMES, 64) frames, each with present and
// evictable flags and its last k access stamps (k = history_depth, clamped to 1..MAX_K)
// kept newest first in a history memory with two registered read ports. One request is
// handled at a time and req_ready is high only when the block is idle; the result sits
// in an output register, so a new request is taken while it waits. Out-of-range ids,
// set evictable and remove go from decode straight to the result state. A record access
// reads the fill count, then shifts the history, moving each of the stamps kept after it
// (at most MAX_K) one slot older through the single write port, newest stamp last. An
// evict scans all frames: the scan pipeline reads one frame's fill and two history words
// per cycle and a shared comparator keeps the best victim. No clearing pass is needed
// after reset.
`include "lru_k_frame_replacer_top_assert.svh"

module lru_k_frame_replacer_top #(
   parameter int MAX_FRAMES = 64,
   parameter int MAX_K      = 4,
   parameter int TIME_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  lkfr_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output lkfr_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lkfr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lkfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import lkfr_pkg::*;

   localparam int NUM_FR = (MAX_FRAMES < FRAME_LIMIT) ? MAX_FRAMES : FRAME_LIMIT;
   localparam int FW     = $clog2(NUM_FR);
   localparam int KW     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam int FILLW  = $clog2(MAX_K + 1);
   localparam int HDEPTH = NUM_FR << KW;

   // control state
   fsm_type                state_ff, state_in;
   logic [NUM_FR-1:0]      present_ff, present_in;
   logic [NUM_FR-1:0]      evict_ff, evict_in;
   logic [TOTAL_W-1:0]     evict_cnt_ff, evict_cnt_in;
   logic [TIME_BITS-1:0]   time_ff, time_in;
   logic [COUNT_W-1:0]     frame_count_ff, frame_count_in;
   logic [DEPTH_W-1:0]     depth_ff, depth_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   scan_run_ff, scan_run_in;
   logic                   b_vld_ff, b_vld_in;
   logic                   c_vld_ff, c_vld_in;
   logic                   best_found_ff, best_found_in;

   // payload state
   req_type                req_ff, req_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   status_type             res_status_ff, res_status_in;
   logic                   res_vvalid_ff, res_vvalid_in;
   logic [FRAME_W-1:0]     res_vframe_ff, res_vframe_in;
   logic [TIME_BITS-1:0]   stamp_ff, stamp_in;
   logic [KW-1:0]          shift_idx_ff, shift_idx_in;
   logic [FW-1:0]          a_idx_ff, a_idx_in;
   logic [FW-1:0]          b_idx_ff, b_idx_in;
   logic                   b_cand_ff, b_cand_in;
   logic [FW-1:0]          c_idx_ff, c_idx_in;
   logic                   c_cand_ff, c_cand_in;
   logic                   c_inf_ff, c_inf_in;
   logic [FW-1:0]          best_idx_ff, best_idx_in;
   logic                   best_inf_ff, best_inf_in;
   logic [TIME_BITS-1:0]   best_kth_ff, best_kth_in;
   logic [TIME_BITS-1:0]   best_old_ff, best_old_in;

   // memories
   logic [FILLW-1:0]       meta_mem_ff [NUM_FR];
   logic [FILLW-1:0]       meta_rd_ff;
   logic [TIME_BITS-1:0]   hist_mem_ff [HDEPTH];
   logic [TIME_BITS-1:0]   hist_rd0_ff, hist_rd1_ff;
   logic [FW-1:0]          meta_raddr;
   logic                   meta_we;
   logic [FILLW-1:0]       meta_wdata;
   logic [FW+KW-1:0]       hist_raddr0, hist_raddr1, hist_waddr;
   logic                   hist_we;
   logic [TIME_BITS-1:0]   hist_wdata;

   // datapath helpers
   logic [FW-1:0]          frame_idx;
   logic                   frame_in_range;
   logic [FILLW-1:0]       k_eff, k_m1;
   logic [FILLW-1:0]       fill_old, fill_new, shift_j, fill_b_m1;
   logic [FILLW:0]         fill_sum;
   logic                   cand_wins;
   logic                   req_fire, rsp_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_fire  = req_valid & req_ready;
   assign rsp_fire  = rsp_valid_ff & rsp_ready;

   assign frame_idx      = req_ff.frame[FW-1:0];
   assign frame_in_range = ({1'b0, req_ff.frame} < frame_count_ff) &&
                           ({1'b0, req_ff.frame} < COUNT_W'(NUM_FR));

   always_comb begin
      if (depth_ff == '0) begin
         k_eff = FILLW'(1);
      end else if (32'(depth_ff) > MAX_K) begin
         k_eff = FILLW'(MAX_K);
      end else begin
         k_eff = FILLW'(depth_ff);
      end
   end

   assign k_m1      = k_eff - FILLW'(1);
   assign fill_old  = present_ff[frame_idx] ? meta_rd_ff : '0;
   assign fill_sum  = {1'b0, fill_old} + (FILLW+1)'(1);
   assign fill_new  = (fill_sum > {1'b0, k_eff}) ? k_eff : fill_sum[FILLW-1:0];
   assign shift_j   = fill_new - FILLW'(1);
   assign fill_b_m1 = meta_rd_ff - FILLW'(1);

   // shared comparator: does the frame in the last scan stage beat the best so far
   always_comb begin
      if (c_inf_ff != best_inf_ff) begin
         cand_wins = c_inf_ff;
      end else if (!c_inf_ff && (hist_rd0_ff != best_kth_ff)) begin
         cand_wins = hist_rd0_ff < best_kth_ff;
      end else begin
         cand_wins = hist_rd1_ff < best_old_ff;
      end
   end

   always_comb begin
      state_in       = state_ff;
      present_in     = present_ff;
      evict_in       = evict_ff;
      evict_cnt_in   = evict_cnt_ff;
      time_in        = time_ff;
      frame_count_in = frame_count_ff;
      depth_in       = depth_ff;
      rsp_valid_in   = rsp_fire ? 1'b0 : rsp_valid_ff;
      scan_run_in    = scan_run_ff;
      b_vld_in       = b_vld_ff;
      c_vld_in       = c_vld_ff;
      best_found_in  = best_found_ff;
      req_in         = req_ff;
      rsp_data_in    = rsp_data_ff;
      res_status_in  = res_status_ff;
      res_vvalid_in  = res_vvalid_ff;
      res_vframe_in  = res_vframe_ff;
      stamp_in       = stamp_ff;
      shift_idx_in   = shift_idx_ff;
      a_idx_in       = a_idx_ff;
      b_idx_in       = b_idx_ff;
      b_cand_in      = b_cand_ff;
      c_idx_in       = c_idx_ff;
      c_cand_in      = c_cand_ff;
      c_inf_in       = c_inf_ff;
      best_idx_in    = best_idx_ff;
      best_inf_in    = best_inf_ff;
      best_kth_in    = best_kth_ff;
      best_old_in    = best_old_ff;
      meta_raddr     = frame_idx;
      meta_we        = 1'b0;
      meta_wdata     = fill_new;
      hist_raddr0    = {frame_idx, shift_idx_ff};
      hist_raddr1    = {frame_idx, shift_idx_ff};
      hist_we        = 1'b0;
      hist_waddr     = {frame_idx, shift_idx_ff};
      hist_wdata     = hist_rd0_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_FRAME_COUNT:   frame_count_in = csr_wdata[COUNT_W-1:0];
            CSR_HISTORY_DEPTH: depth_in = csr_wdata[DEPTH_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in   = req_data;
               state_in = S_DECODE;
            end
         end

         S_DECODE: begin
            res_status_in = ST_OK;
            res_vvalid_in = 1'b0;
            res_vframe_in = '0;
            if (req_ff.opcode != OP_EVICT && !frame_in_range) begin
               res_status_in = ST_BAD_FRAME;
               state_in      = S_DONE;
            end else begin
               unique case (req_ff.opcode)
                  OP_ACCESS: begin
                     state_in = S_META;
                  end
                  OP_SET_EVICT: begin
                     if (present_ff[frame_idx]) begin
                        if (req_ff.evictable_flag && !evict_ff[frame_idx]) begin
                           evict_cnt_in = evict_cnt_ff + TOTAL_W'(1);
                        end else if (!req_ff.evictable_flag && evict_ff[frame_idx] &&
                                     evict_cnt_ff != '0) begin
                           evict_cnt_in = evict_cnt_ff - TOTAL_W'(1);
                        end
                        evict_in[frame_idx] = req_ff.evictable_flag;
                     end
                     state_in = S_DONE;
                  end
                  OP_REMOVE: begin
                     if (present_ff[frame_idx]) begin
                        if (!evict_ff[frame_idx]) begin
                           res_status_in = ST_PINNED;
                        end else begin
                           present_in[frame_idx] = 1'b0;
                           evict_in[frame_idx]   = 1'b0;
                           if (evict_cnt_ff != '0) begin
                              evict_cnt_in = evict_cnt_ff - TOTAL_W'(1);
                           end
                        end
                     end
                     state_in = S_DONE;
                  end
                  OP_EVICT: begin
                     a_idx_in      = '0;
                     scan_run_in   = 1'b1;
                     b_vld_in      = 1'b0;
                     c_vld_in      = 1'b0;
                     best_found_in = 1'b0;
                     state_in      = S_SCAN;
                  end
                  default: ;
               endcase
            end
         end

         S_META: begin
            // fill count is back from the metadata memory
            meta_we                = 1'b1;
            present_in[frame_idx]  = 1'b1;
            stamp_in               = time_ff;
            if (time_ff != '1) begin
               time_in = time_ff + TIME_BITS'(1);
            end
            shift_idx_in = shift_j[KW-1:0];
            hist_raddr0  = {frame_idx, shift_j[KW-1:0] - KW'(1)};
            state_in     = S_SHIFT;
         end

         S_SHIFT: begin
            // move each kept stamp one slot older, newest stamp goes in last
            hist_we = 1'b1;
            if (shift_idx_ff == '0) begin
               hist_wdata = stamp_ff;
               state_in   = S_DONE;
            end else begin
               hist_raddr0  = {frame_idx, shift_idx_ff - KW'(1) - KW'(1)};
               shift_idx_in = shift_idx_ff - KW'(1);
            end
         end

         S_SCAN: begin
            // stage a: flags and fill read
            meta_raddr = a_idx_ff;
            b_vld_in   = scan_run_ff;
            b_idx_in   = a_idx_ff;
            b_cand_in  = present_ff[a_idx_ff] & evict_ff[a_idx_ff];
            if (scan_run_ff) begin
               if (a_idx_ff == FW'(NUM_FR - 1)) begin
                  scan_run_in = 1'b0;
               end else begin
                  a_idx_in = a_idx_ff + FW'(1);
               end
            end

            // stage b: k-th newest and oldest kept stamp read
            c_vld_in    = b_vld_ff;
            c_idx_in    = b_idx_ff;
            c_cand_in   = b_cand_ff;
            c_inf_in    = meta_rd_ff < k_eff;
            hist_raddr0 = {b_idx_ff, k_m1[KW-1:0]};
            hist_raddr1 = {b_idx_ff, fill_b_m1[KW-1:0]};

            // stage c: compare, ties keep the lower id seen first
            if (c_vld_ff && c_cand_ff && (!best_found_ff || cand_wins)) begin
               best_found_in = 1'b1;
               best_idx_in   = c_idx_ff;
               best_inf_in   = c_inf_ff;
               best_kth_in   = hist_rd0_ff;
               best_old_in   = hist_rd1_ff;
            end

            if (!scan_run_ff && !b_vld_ff && !c_vld_ff) begin
               if (best_found_ff) begin
                  present_in[best_idx_ff] = 1'b0;
                  evict_in[best_idx_ff]   = 1'b0;
                  if (evict_cnt_ff != '0) begin
                     evict_cnt_in = evict_cnt_ff - TOTAL_W'(1);
                  end
                  res_status_in = ST_OK;
                  res_vvalid_in = 1'b1;
                  res_vframe_in = FRAME_W'(best_idx_ff);
               end else begin
                  res_status_in = ST_NO_VICTIM;
               end
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.status          = res_status_ff;
               rsp_data_in.victim_valid    = res_vvalid_ff;
               rsp_data_in.victim_id       = res_vframe_ff;
               rsp_data_in.evictable_total = evict_cnt_ff;
               state_in                    = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         present_ff     <= '0;
         evict_ff       <= '0;
         evict_cnt_ff   <= '0;
         time_ff        <= '0;
         frame_count_ff <= FRAME_COUNT_RESET;
         depth_ff       <= HISTORY_DEPTH_RESET;
         rsp_valid_ff   <= 1'b0;
         scan_run_ff    <= 1'b0;
         b_vld_ff       <= 1'b0;
         c_vld_ff       <= 1'b0;
         best_found_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         present_ff     <= present_in;
         evict_ff       <= evict_in;
         evict_cnt_ff   <= evict_cnt_in;
         time_ff        <= time_in;
         frame_count_ff <= frame_count_in;
         depth_ff       <= depth_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_run_ff    <= scan_run_in;
         b_vld_ff       <= b_vld_in;
         c_vld_ff       <= c_vld_in;
         best_found_ff  <= best_found_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      rsp_data_ff   <= rsp_data_in;
      res_status_ff <= res_status_in;
      res_vvalid_ff <= res_vvalid_in;
      res_vframe_ff <= res_vframe_in;
      stamp_ff      <= stamp_in;
      shift_idx_ff  <= shift_idx_in;
      a_idx_ff      <= a_idx_in;
      b_idx_ff      <= b_idx_in;
      b_cand_ff     <= b_cand_in;
      c_idx_ff      <= c_idx_in;
      c_cand_ff     <= c_cand_in;
      c_inf_ff      <= c_inf_in;
      best_idx_ff   <= best_idx_in;
      best_inf_ff   <= best_inf_in;
      best_kth_ff   <= best_kth_in;
      best_old_ff   <= best_old_in;
   end

   // fill count per frame, only meaningful while the frame is present
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem_ff[frame_idx] <= meta_wdata;
      end
      meta_rd_ff <= meta_mem_ff[meta_raddr];
   end

   // access stamps, slot j of a frame holds its j-th newest access
   always_ff @(posedge clock) begin
      if (hist_we) begin
         hist_mem_ff[hist_waddr] <= hist_wdata;
      end
      hist_rd0_ff <= hist_mem_ff[hist_raddr0];
      hist_rd1_ff <= hist_mem_ff[hist_raddr1];
   end

   `LKFR_ASSERT_ALWAYS(a_evict_count, clock, reset, $countones(evict_ff) == 32'(evict_cnt_ff), "evictable count out of step with flags")
   `LKFR_ASSERT_ALWAYS(a_evict_present, clock, reset, (evict_ff & ~present_ff) == '0, "evictable frame not present")
   `LKFR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "new transaction taken while busy")
   `LKFR_ASSERT_ALWAYS(a_victim_ok, clock, reset, !rsp_valid || !rsp_data.victim_valid || rsp_data.status == ST_OK, "victim reported with error status")

endmodule

@@ sim/tb_top.sv @@
module tb_top;
   import lkfr_pkg::*;

   localparam int          HIST_MAX    = 4;
   localparam logic [31:0] STAMP_MAX   = 32'hFFFF_FFFF;
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          TAIL_CYCLES = 120;
   localparam int          FIFO_DEPTH  = 16;

   // indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   req_type                req_data;
   logic                   rsp_valid;
   logic                   rsp_ready;
   rsp_type                rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   lru_k_frame_replacer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // replacer shadow state
   logic        frame_live     [FRAME_LIMIT];
   logic        frame_unpinned [FRAME_LIMIT];
   logic [31:0] stamp_hist     [FRAME_LIMIT][HIST_MAX];
   int unsigned stamp_fill     [FRAME_LIMIT];
   logic [31:0] access_clock;
   logic [6:0]  evictable_tally;
   logic [6:0]  cfg_frame_count;
   logic [2:0]  cfg_depth;

   // expected results in order, written by the sender and read by the checker
   rsp_type     outcome_fifo [FIFO_DEPTH];
   int          outcome_wr;
   int          outcome_rd;
   int          n_requests;
   int          n_victims;
   int          n_rejected;
   int          n_pinned;
   int          n_csr_writes;
   int          n_errors;
   int          cycle_count;
   bit          idle_on;

   initial begin
      clock = 1'b0;
   end

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic int outcomes_waiting();
      return outcome_wr - outcome_rd;
   endfunction

   function automatic int unsigned depth_in_use();
      int unsigned k;
      k = 32'(cfg_depth);
      if (k == 0) k = 1;
      if (k > HIST_MAX) k = HIST_MAX;
      return k;
   endfunction

   function automatic int unsigned frames_in_use();
      return (cfg_frame_count > FRAME_LIMIT) ? FRAME_LIMIT : cfg_frame_count;
   endfunction

   // true when frame a goes out ahead of frame b
   function automatic bit evicts_first(int a, int b, int unsigned k);
      int unsigned fa;
      int unsigned fb;
      bit          inf_a;
      bit          inf_b;
      logic [31:0] old_a;
      logic [31:0] old_b;
      logic [31:0] ka;
      logic [31:0] kb;
      fa = stamp_fill[a];
      fb = stamp_fill[b];
      inf_a = fa < k;
      inf_b = fb < k;
      old_a = '0;
      old_b = '0;
      if (fa != 0) old_a = stamp_hist[a][fa-1];
      if (fb != 0) old_b = stamp_hist[b][fb-1];
      if (inf_a != inf_b) return inf_a;
      if (!inf_a) begin
         ka = stamp_hist[a][k-1];
         kb = stamp_hist[b][k-1];
         if (ka != kb) return ka < kb;
      end
      if (old_a != old_b) return old_a < old_b;
      return a < b;
   endfunction

   function automatic rsp_type replace_outcome(req_type r);
      rsp_type     o;
      int unsigned k;
      int          f;
      int          best;
      bit          found;
      o = '0;
      o.status = ST_OK;
      k = depth_in_use();
      f = int'(r.frame);
      best = 0;
      found = 1'b0;
      if (r.opcode != OP_EVICT && r.frame >= frames_in_use()) begin
         o.status = ST_BAD_FRAME;
         n_rejected++;
      end else begin
         case (r.opcode)
            OP_ACCESS: begin
               if (!frame_live[f]) begin
                  frame_live[f] = 1'b1;
                  frame_unpinned[f] = 1'b0;
                  stamp_fill[f] = 0;
               end
               for (int i = HIST_MAX - 1; i > 0; i--)
                  stamp_hist[f][i] = stamp_hist[f][i-1];
               stamp_hist[f][0] = access_clock;
               if (access_clock != STAMP_MAX) access_clock++;
               stamp_fill[f] = (stamp_fill[f] + 1 > k) ? k : stamp_fill[f] + 1;
            end
            OP_SET_EVICT: begin
               if (frame_live[f]) begin
                  if (r.evictable_flag && !frame_unpinned[f])
                     evictable_tally++;
                  else if (!r.evictable_flag && frame_unpinned[f] && evictable_tally != 0)
                     evictable_tally--;
                  frame_unpinned[f] = r.evictable_flag;
               end
            end
            OP_REMOVE: begin
               if (frame_live[f]) begin
                  if (!frame_unpinned[f]) begin
                     o.status = ST_PINNED;
                     n_pinned++;
                  end else begin
                     frame_live[f] = 1'b0;
                     frame_unpinned[f] = 1'b0;
                     stamp_fill[f] = 0;
                     if (evictable_tally != 0) evictable_tally--;
                  end
               end
            end
            default: begin
               for (int g = 0; g < FRAME_LIMIT; g++) begin
                  if (frame_live[g] && frame_unpinned[g]) begin
                     if (!found || evicts_first(g, best, k)) begin
                        best = g;
                        found = 1'b1;
                     end
                  end
               end
               if (!found) begin
                  o.status = ST_NO_VICTIM;
               end else begin
                  frame_live[best] = 1'b0;
                  frame_unpinned[best] = 1'b0;
                  stamp_fill[best] = 0;
                  if (evictable_tally != 0) evictable_tally--;
                  o.victim_valid = 1'b1;
                  o.victim_id = best[FRAME_W-1:0];
                  n_victims++;
               end
            end
         endcase
      end
      o.evictable_total = evictable_tally;
      return o;
   endfunction

   task automatic send_request(input opcode_type op, input int fr, input logic fl);
      req_type item;
      item.opcode = op;
      item.frame = fr[FRAME_W-1:0];
      item.evictable_flag = fl;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = item;
      do @(posedge clock); while (!req_ready);
      outcome_fifo[outcome_wr % FIFO_DEPTH] = replace_outcome(item);
      outcome_wr++;
      n_requests++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (outcomes_waiting() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_FRAME_COUNT) cfg_frame_count = value[6:0];
      else if (idx == CSR_HISTORY_DEPTH) cfg_depth = value[2:0];
      n_csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(input int fc, input int depth);
      drain_results();
      write_register(CSR_FRAME_COUNT, fc);
      write_register(CSR_HISTORY_DEPTH, depth);
   endtask

   // result side: random stall bursts while idling is enabled
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 11) - 1) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (outcomes_waiting() == 0) begin
            $display("%0t: unexpected result: actual status=%0d victim=%0b/%0d total=%0d",
                     $time, rsp_data.status, rsp_data.victim_valid, rsp_data.victim_id,
                     rsp_data.evictable_total);
            n_errors++;
         end else begin
            want = outcome_fifo[outcome_rd % FIFO_DEPTH];
            outcome_rd++;
            if (rsp_data.status !== want.status ||
                rsp_data.victim_valid !== want.victim_valid ||
                rsp_data.victim_id !== want.victim_id ||
                rsp_data.evictable_total !== want.evictable_total) begin
               $display("%0t: mismatch: expected status=%0d victim=%0b/%0d total=%0d",
                        $time, want.status, want.victim_valid, want.victim_id,
                        want.evictable_total);
               $display("%0t:           actual   status=%0d victim=%0b/%0d total=%0d",
                        $time, rsp_data.status, rsp_data.victim_valid,
                        rsp_data.victim_id, rsp_data.evictable_total);
               n_errors++;
            end
         end
      end
   end

   task automatic test_basic_ops();
      send_request(OP_EVICT, 0, 1'b0);          // nothing to evict yet
      send_request(OP_ACCESS, 0, 1'b1);
      send_request(OP_ACCESS, 63, 1'b0);
      send_request(OP_ACCESS, 0, 1'b0);
      send_request(OP_SET_EVICT, 63, 1'b1);
      send_request(OP_SET_EVICT, 0, 1'b1);
      send_request(OP_SET_EVICT, 63, 1'b1);     // already evictable, count holds
      send_request(OP_EVICT, 42, 1'b1);         // short history goes first
      send_request(OP_REMOVE, 5, 1'b0);         // absent frames change nothing
      send_request(OP_SET_EVICT, 7, 1'b1);
      send_request(OP_ACCESS, 10, 1'b0);
      send_request(OP_REMOVE, 10, 1'b0);        // pinned
      send_request(OP_SET_EVICT, 10, 1'b1);
      send_request(OP_SET_EVICT, 10, 1'b0);
      send_request(OP_SET_EVICT, 10, 1'b1);
      send_request(OP_REMOVE, 10, 1'b1);
      send_request(OP_EVICT, 63, 1'b0);
      send_request(OP_EVICT, 0, 1'b1);
   endtask

   task automatic test_frame_limits();
      send_request(OP_ACCESS, 40, 1'b0);
      send_request(OP_SET_EVICT, 40, 1'b1);
      configure(5, 2);
      send_request(OP_SET_EVICT, 40, 1'b0);     // above the limit now
      send_request(OP_EVICT, 0, 1'b0);          // still evictable though
      configure(0, 2);
      send_request(OP_ACCESS, 0, 1'b0);
      send_request(OP_REMOVE, 0, 1'b0);
      configure(1, 2);
      send_request(OP_ACCESS, 1, 1'b0);
      send_request(OP_ACCESS, 0, 1'b0);
      configure(127, 2);                        // clamps to the frame limit
      send_request(OP_ACCESS, 63, 1'b0);
   endtask

   task automatic test_history_depth();
      configure(64, 7);                         // clamps to the deepest history
      for (int i = 0; i < 4; i++) begin
         send_request(OP_ACCESS, 2, 1'b0);
         send_request(OP_ACCESS, 3, 1'b0);
      end
      send_request(OP_SET_EVICT, 3, 1'b1);
      send_request(OP_SET_EVICT, 2, 1'b1);
      drain_results();
      write_register(CSR_SPARE_LO, 127);
      write_register(CSR_SPARE_HI, 0);
      write_register(CSR_HISTORY_DEPTH, 0);     // acts as depth one
      send_request(OP_EVICT, 0, 1'b0);
      send_request(OP_EVICT, 0, 1'b0);
   endtask

   task automatic random_traffic(input int count);
      int unsigned fc_eff;
      int unsigned k;
      int          hot;
      int          base;
      int          roll;
      int          fr;
      int          sent;
      fc_eff = frames_in_use();
      k = depth_in_use();
      hot = (fc_eff > 8) ? 8 : fc_eff;
      base = (fc_eff > 0) ? $urandom_range(0, fc_eff - hot) : 0;
      sent = 0;
      while (sent < count) begin
         if (hot != 0 && $urandom_range(0, 99) < 70)
            fr = base + $urandom_range(0, hot - 1);
         else
            fr = $urandom_range(0, FRAME_LIMIT - 1);
         roll = $urandom_range(0, 99);
         if (roll < 20) begin
            // well-formed use: touch a frame a few times, then unpin it
            repeat ($urandom_range(1, k + 1)) begin
               send_request(OP_ACCESS, fr, 1'($urandom_range(0, 1)));
               sent++;
            end
            send_request(OP_SET_EVICT, fr, 1'b1);
            sent++;
         end else if (roll < 50) begin
            send_request(OP_ACCESS, fr, 1'($urandom_range(0, 1)));
            sent++;
         end else if (roll < 68) begin
            send_request(OP_SET_EVICT, fr, $urandom_range(0, 99) < 75);
            sent++;
         end else if (roll < 78) begin
            send_request(OP_REMOVE, fr, 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            send_request(OP_EVICT, $urandom_range(0, FRAME_LIMIT - 1),
                         1'($urandom_range(0, 1)));
            sent++;
         end
      end
   endtask

   task automatic test_random_settings();
      int fc_set[8]    = '{64, 1, 5, 127, 20, 40, 64, 33};
      int depth_set[8] = '{2, 1, 4, 3, 7, 0, 4, 1};
      for (int p = 0; p < 8; p++) begin
         configure(fc_set[p], depth_set[p]);
         random_traffic(200);
      end
   endtask

   task automatic test_streaming();
      configure(64, 3);
      idle_on = 1'b0;
      random_traffic(260);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      idle_on = 1'b1;
      cycle_count = 0;
      outcome_wr = 0;
      outcome_rd = 0;
      n_requests = 0;
      n_victims = 0;
      n_rejected = 0;
      n_pinned = 0;
      n_csr_writes = 0;
      n_errors = 0;
      access_clock = '0;
      evictable_tally = '0;
      cfg_frame_count = FRAME_COUNT_RESET;
      cfg_depth = HISTORY_DEPTH_RESET;
      for (int f = 0; f < FRAME_LIMIT; f++) begin
         frame_live[f] = 1'b0;
         frame_unpinned[f] = 1'b0;
         stamp_fill[f] = 0;
         for (int i = 0; i < HIST_MAX; i++) stamp_hist[f][i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_ops();
      test_frame_limits();
      test_history_depth();
      test_random_settings();
      test_streaming();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("ran %0d requests: %0d victims, %0d rejected ids, %0d pinned removes",
               n_requests, n_victims, n_rejected, n_pinned);
      $display("%0d register writes over frame counts 0 to 127 and depths 0 to 7",
               n_csr_writes);
      if (n_errors == 0 && outcomes_waiting() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d results missing", n_errors, outcomes_waiting());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ lru_k_frame_replacer_top.f @@
+incdir+rtl/core
rtl/core/lkfr_pkg.sv
rtl/core/lru_k_frame_replacer_top.sv
sim/tb_top.sv
